FILE: rtl/core/lfuvs_pkg.sv
// lfuvs_pkg: shared types, codes and sizes of the lfu victim select block
// depends on nothing; imported by every module under rtl/core
package lfuvs_pkg;

  // table size and derived widths
  localparam int FRAME_COUNT = 1024;
  localparam int ADDR_W      = $clog2(FRAME_COUNT);
  localparam int FRAME_W     = 10;
  localparam int COUNT_W     = 16;
  localparam int PAGE_W      = 20;
  localparam int CMP_W       = ((ADDR_W > FRAME_W) ? ADDR_W : FRAME_W) + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_COUNT - 1);

  // operation codes of an input beat
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_WRITE_DONE = 2'd0,
    STAT_FOUND      = 2'd1,
    STAT_NO_PAGE    = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  // one frame table entry
  typedef struct packed {
    logic               holds_page;
    logic [COUNT_W-1:0] use_count;
    logic [PAGE_W-1:0]  page_number;
  } entry_t;

  // table port request from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } tbl_req_t;

  // control of the shared compare unit
  typedef struct packed {
    logic              clr;
    logic              en;
    logic [ADDR_W-1:0] idx;
  } cmp_ctl_t;

endpackage

FILE: rtl/core/lfuvs_table.sv
// lfuvs_table: frame table memory, one write and one registered read per cycle
// depends on lfuvs_pkg
module lfuvs_table
  import lfuvs_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rd_data
);

  entry_t mem [FRAME_COUNT];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/lfuvs_cmp.sv
// lfuvs_cmp: shared compare unit holding the best candidate of a running scan
// depends on lfuvs_pkg
module lfuvs_cmp
  import lfuvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmp_ctl_t          ctl,
  input  entry_t            ent,
  output logic              found,
  output logic [ADDR_W-1:0] best_idx
);

  logic               found_r, found_nxt;
  logic [ADDR_W-1:0]  best_idx_r, best_idx_nxt;
  logic [COUNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [PAGE_W-1:0]  best_page_r, best_page_nxt;
  logic               take;

  // smaller count wins, on equal counts a strictly larger page wins
  assign take = ctl.en && ent.holds_page &&
                (!found_r || (ent.use_count < best_cnt_r) ||
                 ((ent.use_count == best_cnt_r) && (ent.page_number > best_page_r)));

  always_comb begin
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_cnt_nxt  = best_cnt_r;
    best_page_nxt = best_page_r;
    priority if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = ctl.idx;
      best_cnt_nxt  = ent.use_count;
      best_page_nxt = ent.page_number;
    end
  end

  // found flag is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  // best candidate payload
  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_page_r <= best_page_nxt;
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;

endmodule

FILE: rtl/core/lfuvs_ctrl.sv
// lfuvs_ctrl: sequencer for clearing, writes and victim scans, plus result register
// depends on lfuvs_pkg
module lfuvs_ctrl
  import lfuvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [FRAME_W-1:0] in_frame_index,
  input  logic               in_holds_page,
  input  logic [COUNT_W-1:0] in_use_count,
  input  logic [PAGE_W-1:0]  in_page_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAME_W-1:0] out_victim_frame,
  output logic [1:0]         out_status,
  output tbl_req_t           tbl_req,
  output cmp_ctl_t           cmp_ctl,
  input  logic               cmp_found,
  input  logic [ADDR_W-1:0]  cmp_best_idx
);

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  status_t            out_status_r, out_status_nxt;

  logic in_fire;
  logic out_free;
  logic in_range;
  logic cnt_last;
  logic wr_fire;
  logic sel_fire;
  logic resp_load;

  // handshake terms
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign wr_fire  = in_fire && (in_op == OP_WRITE);
  assign sel_fire = in_fire && (in_op == OP_SELECT);
  assign in_range = CMP_W'(in_frame_index) < CMP_W'(FRAME_COUNT);
  assign cnt_last = cnt_r == LAST_ADDR;
  assign resp_load = (state_r == ST_RESP) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (cnt_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (sel_fire) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_RESP;
      ST_RESP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs: table port, compare unit, sweep counter
  always_comb begin
    tbl_req.wr_en   = 1'b0;
    tbl_req.wr_addr = ADDR_W'(in_frame_index);
    tbl_req.wr_data = '{holds_page: in_holds_page, use_count: in_use_count,
                        page_number: in_page_number};
    tbl_req.rd_en   = 1'b0;
    tbl_req.rd_addr = cnt_r;
    cmp_ctl.clr     = 1'b0;
    cmp_ctl.en      = rd_vld_r;
    cmp_ctl.idx     = rd_addr_r;
    cnt_nxt         = '0;
    rd_vld_nxt      = 1'b0;
    rd_addr_nxt     = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = cnt_r;
        tbl_req.wr_data = '0;
        cnt_nxt         = cnt_last ? '0 : cnt_r + 1'b1;
      end
      ST_IDLE: begin
        tbl_req.wr_en = wr_fire && in_range;
        cmp_ctl.clr   = sel_fire;
      end
      ST_SCAN: begin
        tbl_req.rd_en = 1'b1;
        rd_vld_nxt    = 1'b1;
        cnt_nxt       = cnt_last ? '0 : cnt_r + 1'b1;
      end
      ST_DRAIN, ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_frame_nxt  = out_frame_r;
    out_status_nxt = out_status_r;
    priority if (wr_fire) begin
      out_valid_nxt  = 1'b1;
      out_frame_nxt  = '0;
      out_status_nxt = STAT_WRITE_DONE;
    end else if (resp_load) begin
      out_valid_nxt  = 1'b1;
      out_frame_nxt  = cmp_found ? FRAME_W'(cmp_best_idx) : '0;
      out_status_nxt = cmp_found ? STAT_FOUND : STAT_NO_PAGE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    out_frame_r  <= out_frame_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_victim_frame = out_frame_r;
  assign out_status       = out_status_r;

endmodule

FILE: rtl/core/lfu_victim_select_unit.sv
// lfu_victim_select_unit: write beat answers in the cycle after acceptance
// select beat scans one table entry per cycle through the shared compare unit;
// its result is registered in ST_RESP after ST_SCAN and ST_DRAIN; one item at a time
// the single table read port and the scan counter pace the scan
// reset (rst_n low, synchronous) starts a clearing pass that writes every one of the
// FRAME_COUNT table entries; in_ready stays low until it ends
module lfu_victim_select_unit
  import lfuvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [FRAME_W-1:0] in_frame_index,
  input  logic               in_holds_page,
  input  logic [COUNT_W-1:0] in_use_count,
  input  logic [PAGE_W-1:0]  in_page_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAME_W-1:0] out_victim_frame,
  output logic [1:0]         out_status
);

  tbl_req_t          tbl_req;
  cmp_ctl_t          cmp_ctl;
  entry_t            rd_data;
  logic              cmp_found;
  logic [ADDR_W-1:0] cmp_best_idx;

  // sequencer and result register
  lfuvs_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_frame_index   (in_frame_index),
    .in_holds_page    (in_holds_page),
    .in_use_count     (in_use_count),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_victim_frame (out_victim_frame),
    .out_status       (out_status),
    .tbl_req          (tbl_req),
    .cmp_ctl          (cmp_ctl),
    .cmp_found        (cmp_found),
    .cmp_best_idx     (cmp_best_idx)
  );

  // frame table
  lfuvs_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  // shared compare unit
  lfuvs_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cmp_ctl),
    .ent      (rd_data),
    .found    (cmp_found),
    .best_idx (cmp_best_idx)
  );

endmodule

FILE: rtl/core/lfuvs_checker.sv
// lfuvs_checker: port-level assertions for lfu_victim_select_unit
// depends on lfuvs_pkg; attached to the top level by the bind below
module lfuvs_checker
  import lfuvs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_op,
  input logic [FRAME_W-1:0] in_frame_index,
  input logic               in_holds_page,
  input logic [COUNT_W-1:0] in_use_count,
  input logic [PAGE_W-1:0]  in_page_number,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAME_W-1:0] out_victim_frame,
  input logic [1:0]         out_status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_victim_frame))
    else $error("result beat changed while stalled");

  // only the found status carries a frame
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_FOUND) |-> out_victim_frame == '0)
    else $error("frame nonzero without a victim");

  // a write beat answers in the next cycle with write done
  a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_WRITE) |=>
      out_valid && (out_status == STAT_WRITE_DONE))
    else $error("write beat not answered next cycle");

  // a select beat never answers write done
  a_sel_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $rose(out_valid) && !$past(in_valid && in_ready) |->
      (out_status == STAT_FOUND) || (out_status == STAT_NO_PAGE))
    else $error("scan result has a write status");

  // the input side stalls while a scan runs
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_SELECT) |=> !in_ready)
    else $error("input accepted during a scan");

endmodule

bind lfu_victim_select_unit lfuvs_checker u_lfuvs_checker (.*);

FILE: bench/lfu_victim_select_unit_tb.sv
// lfu_victim_select_unit_tb: self-checking bench for the lfu victim select unit
// keeps its own frame table and least-frequently-used pick to predict every result beat
// depends on lfuvs_pkg and lfu_victim_select_unit only
`timescale 1ns / 100ps

module lfu_victim_select_unit_tb;
  import lfuvs_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT  = 8 * (FRAME_COUNT + 100);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    status_t            status;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_WRITE;
  logic [FRAME_W-1:0] in_frame_index = '0;
  logic               in_holds_page = 1'b0;
  logic [COUNT_W-1:0] in_use_count = '0;
  logic [PAGE_W-1:0]  in_page_number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FRAME_W-1:0] out_victim_frame;
  logic [1:0]         out_status;

  // shadow frame table
  bit                 tbl_flag  [FRAME_COUNT];
  logic [COUNT_W-1:0] tbl_count [FRAME_COUNT];
  logic [PAGE_W-1:0]  tbl_page  [FRAME_COUNT];

  answer_t victim_answers[$];
  int      errors = 0;
  int      quiet_cycles = 0;
  bit      steady = 1'b0;

  lfu_victim_select_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_frame_index  (in_frame_index),
    .in_holds_page   (in_holds_page),
    .in_use_count    (in_use_count),
    .in_page_number  (in_page_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_victim_frame(out_victim_frame),
    .out_status      (out_status)
  );

  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ascending scan: lowest count wins, a strictly larger page breaks a count tie
  function automatic answer_t lfu_pick();
    answer_t            a;
    logic               found;
    logic [COUNT_W-1:0] best_count;
    logic [PAGE_W-1:0]  best_page;
    a.frame    = '0;
    a.status   = STAT_NO_PAGE;
    found      = 1'b0;
    best_count = '0;
    best_page  = '0;
    for (int f = 0; f < FRAME_COUNT; f++) begin
      if (tbl_flag[f]) begin
        if (!found || tbl_count[f] < best_count ||
            (tbl_count[f] == best_count && tbl_page[f] > best_page)) begin
          found      = 1'b1;
          a.frame    = FRAME_W'(f);
          best_count = tbl_count[f];
          best_page  = tbl_page[f];
        end
      end
    end
    if (found) a.status = STAT_FOUND;
    return a;
  endfunction

  // present one beat, wait for acceptance, record the predicted answer
  task automatic send_beat(input logic op, input logic [FRAME_W-1:0] idx,
                           input logic hp, input logic [COUNT_W-1:0] cnt,
                           input logic [PAGE_W-1:0] pg);
    answer_t a;
    int      gap;
    in_valid       <= 1'b1;
    in_op          <= op;
    in_frame_index <= idx;
    in_holds_page  <= hp;
    in_use_count   <= cnt;
    in_page_number <= pg;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (op == OP_WRITE) begin
      // an index past the table is dropped but still answered
      if (idx < FRAME_COUNT) begin
        tbl_flag[idx]  = hp;
        tbl_count[idx] = cnt;
        tbl_page[idx]  = pg;
      end
      a.frame  = '0;
      a.status = STAT_WRITE_DONE;
    end else begin
      a = lfu_pick();
    end
    victim_answers.push_back(a);
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_frame(input logic [FRAME_W-1:0] idx, input logic hp,
                             input logic [COUNT_W-1:0] cnt, input logic [PAGE_W-1:0] pg);
    send_beat(OP_WRITE, idx, hp, cnt, pg);
  endtask

  // unused fields carry noise on a select
  task automatic select_victim();
    send_beat(OP_SELECT, FRAME_W'($urandom), 1'($urandom), COUNT_W'($urandom),
              PAGE_W'($urandom));
  endtask

  // hold the sender off until every answer is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (victim_answers.size() != 0) @(posedge clk);
  endtask

  // one item in four is a select; writes are biased toward a few frames and small values so ties are common
  task automatic random_item();
    logic [FRAME_W-1:0] idx;
    logic [COUNT_W-1:0] cnt;
    logic [PAGE_W-1:0]  pg;
    int                 pick;
    if ($urandom_range(0, 3) == 0) begin
      select_victim();
    end else begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: begin
          idx = FRAME_W'($urandom_range(0, 15));
        end
        1: begin
          idx = FRAME_W'($urandom_range(1008, 1023));
        end
        default: begin
          idx = FRAME_W'($urandom);
        end
      endcase
      cnt = $urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 3)) : COUNT_W'($urandom);
      pg  = $urandom_range(0, 1) ? PAGE_W'($urandom_range(0, 7)) : PAGE_W'($urandom);
      write_frame(idx, $urandom_range(0, 4) != 0, cnt, pg);
    end
  endtask

  // select on an empty table, and after a write that holds no page
  task automatic test_empty_table();
    select_victim();
    write_frame(10'd12, 1'b0, 16'd3, 20'd9);
    select_victim();
  endtask

  // extreme frame indexes, counts and page numbers
  task automatic test_field_extremes();
    write_frame(10'd1023, 1'b1, 16'hffff, 20'hfffff);
    select_victim();
    write_frame(10'd0, 1'b1, 16'h0000, 20'h00000);
    select_victim();
    write_frame(10'd0, 1'b0, 16'h0000, 20'h00000);
    select_victim();
  endtask

  // count ties settled by page number, full ties keep the lowest frame
  task automatic test_tie_breaks();
    write_frame(10'd5, 1'b1, 16'd7, 20'd100);
    write_frame(10'd6, 1'b1, 16'd7, 20'd200);
    select_victim();
    write_frame(10'd7, 1'b1, 16'd7, 20'd200);
    select_victim();
    write_frame(10'd8, 1'b1, 16'd7, 20'd50);
    select_victim();
    write_frame(10'd3, 1'b1, 16'd7, 20'd200);
    select_victim();
    write_frame(10'd9, 1'b1, 16'd6, 20'd0);
    select_victim();
  endtask

  // sender stops until the block has answered everything
  task automatic test_drain_pause();
    write_frame(10'd9, 1'b0, 16'd6, 20'd0);
    select_victim();
    wait_drained();
    select_victim();
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) random_item();
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int n);
    steady = 1'b1;
    repeat (n) random_item();
    steady = 1'b0;
  endtask

  // result side stalls
  initial begin
    int run;
    int gap;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
      if (!steady) begin
        gap = idle_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // compare each result beat with the oldest predicted answer
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (victim_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: victim_frame %0d status %0d",
                 $time, out_victim_frame, out_status);
      end else begin
        want = victim_answers.pop_front();
        if (out_victim_frame !== want.frame) begin
          errors++;
          $display("%0t: victim_frame expected %0d actual %0d",
                   $time, want.frame, out_victim_frame);
        end
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("lfu_victim_select_unit_tb: FAIL");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_field_extremes();
    test_tie_breaks();
    test_drain_pause();
    test_random_traffic(400);
    test_back_to_back(40);
    wait_drained();
    repeat (FRAME_COUNT + 8) @(posedge clk);
    if (errors == 0) begin
      $display("lfu_victim_select_unit_tb: PASS");
    end else begin
      $display("lfu_victim_select_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/lfuvs_pkg.sv
rtl/core/lfuvs_table.sv
rtl/core/lfuvs_cmp.sv
rtl/core/lfuvs_ctrl.sv
rtl/core/lfu_victim_select_unit.sv
rtl/core/lfuvs_checker.sv
bench/lfu_victim_select_unit_tb.sv
